// ===== rtl/assert_macros.svh =====
// assertion macros used by the rtl module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising edge outside reset
`define ASSERT_IMPL(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// property checked at every rising edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error(msg);

`endif

// ===== rtl/tpr_pkg.sv =====
// types, constants and the clamp function of the touch point report parser
package tpr_pkg;

  typedef enum logic [1:0] {
    KIND_POINT     = 2'd0,
    KIND_NOT_READY = 2'd1,
    KIND_BAD_COUNT = 2'd2,
    KIND_EMPTY     = 2'd3
  } kind_t;

  localparam logic [1:0] CFG_SCREEN_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_SCREEN_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_EDGE_MARGIN   = 2'd2;

  localparam logic [11:0] WIDTH_RESET  = 12'd800;
  localparam logic [11:0] HEIGHT_RESET = 12'd480;
  localparam logic [6:0]  MARGIN_RESET = 7'd20;

  localparam int READY_BIT = 7;
  localparam logic [7:0] COUNT_MASK = 8'h0f;

  localparam logic [2:0] POS_TRACK_ID = 3'd0;
  localparam logic [2:0] POS_X_LOW    = 3'd1;
  localparam logic [2:0] POS_X_HIGH   = 3'd2;
  localparam logic [2:0] POS_Y_LOW    = 3'd3;
  localparam logic [2:0] POS_Y_HIGH   = 3'd4;
  localparam logic [2:0] POS_SIZE_LOW = 3'd5;
  localparam logic [2:0] POS_SIZE_HIGH = 3'd6;
  localparam logic [2:0] POS_RESERVED = 3'd7;

  localparam int OUT_DATA_W = 56;

  function automatic logic [11:0] clamp_axis(input logic [15:0] v,
                                             input logic [11:0] extent,
                                             input logic [6:0]  margin);
    logic [11:0] hi;
    logic [15:0] lo_clamped;
    logic [15:0] hi_clamped;
    hi = (extent > {5'd0, margin}) ? extent - {5'd0, margin} : 12'd0;
    lo_clamped = (v < {9'd0, margin}) ? {9'd0, margin} : v;
    hi_clamped = (lo_clamped > {4'd0, hi}) ? {4'd0, hi} : lo_clamped;
    return hi_clamped[11:0];
  endfunction

endpackage

// ===== rtl/touch_point_report_parser_top.sv =====
// touch point report parser: status byte decode, record assembly and clamping
// a result word is registered and is offered on the output in the cycle after the byte that completes it is accepted
// throughput: one byte per cycle, set by the single output register
// input stalls only while a result word waits and the output is not ready
// reset (rst, synchronous) clears parse state and output valid, and loads
// screen 800 x 480 with margin 20
`include "assert_macros.svh"
module touch_point_report_parser_top import tpr_pkg::*; #(
  parameter int MAX_POINTS = 5
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // data_byte
  input  logic                  s_axis_tuser,   // frame_start
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // track_id, pos_x, pos_y, touch_size, point_index
  output logic [1:0]            m_axis_tuser,   // kind
  output logic                  m_axis_tlast,   // last
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [11:0]           cfg_data
);

  localparam int CNT_W = $clog2(MAX_POINTS + 1);

  logic [11:0] screen_width;
  logic [11:0] screen_height;
  logic [6:0]  edge_margin;

  logic             expecting_points, expecting_points_next;
  logic [CNT_W-1:0] points_expected, points_expected_next;
  logic [CNT_W-1:0] point_counter, point_counter_next;
  logic [2:0]       byte_in_record, byte_in_record_next;
  logic [7:0]       held_track_id, held_track_id_next;
  logic [15:0]      held_x, held_x_next;
  logic [15:0]      held_y, held_y_next;
  logic [7:0]       held_size_low, held_size_low_next;

  logic                  out_valid;
  logic [OUT_DATA_W-1:0] out_data;
  kind_t                 out_kind;
  logic                  out_last;

  logic                  accept;
  logic                  produced;
  logic [OUT_DATA_W-1:0] res_data;
  kind_t                 res_kind;
  logic                  res_last;

  logic [3:0]  count;
  logic [11:0] clamped_x;
  logic [11:0] clamped_y;
  logic        is_last;

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tuser  = out_kind;
  assign m_axis_tlast  = out_last;

  assign count     = s_axis_tdata[3:0] & COUNT_MASK[3:0];
  assign clamped_x = clamp_axis(held_x, screen_width, edge_margin);
  assign clamped_y = clamp_axis(held_y, screen_height, edge_margin);
  assign is_last   = ({1'b0, point_counter} + 1'b1) >= {1'b0, points_expected};

  always_comb begin
    expecting_points_next = expecting_points;
    points_expected_next  = points_expected;
    point_counter_next    = point_counter;
    byte_in_record_next   = byte_in_record;
    held_track_id_next    = held_track_id;
    held_x_next           = held_x;
    held_y_next           = held_y;
    held_size_low_next    = held_size_low;
    produced              = 1'b0;
    res_data              = '0;
    res_kind              = KIND_POINT;
    res_last              = 1'b1;
    if (s_axis_tuser) begin
      expecting_points_next = 1'b0;
      points_expected_next  = '0;
      point_counter_next    = '0;
      byte_in_record_next   = POS_TRACK_ID;
      produced              = 1'b1;
      if (!s_axis_tdata[READY_BIT]) begin
        res_kind = KIND_NOT_READY;
      end else if (int'(count) > MAX_POINTS) begin
        res_kind = KIND_BAD_COUNT;
      end else if (count == 4'd0) begin
        res_kind = KIND_EMPTY;
      end else begin
        produced              = 1'b0;
        expecting_points_next = 1'b1;
        points_expected_next  = CNT_W'(count);
      end
    end else if (expecting_points) begin
      case (byte_in_record)
        POS_TRACK_ID:  held_track_id_next = s_axis_tdata;
        POS_X_LOW:     held_x_next = {held_x[15:8], s_axis_tdata};
        POS_X_HIGH:    held_x_next = {s_axis_tdata, held_x[7:0]};
        POS_Y_LOW:     held_y_next = {held_y[15:8], s_axis_tdata};
        POS_Y_HIGH:    held_y_next = {s_axis_tdata, held_y[7:0]};
        POS_SIZE_LOW:  held_size_low_next = s_axis_tdata;
        POS_SIZE_HIGH: begin
          produced = 1'b1;
          res_kind = KIND_POINT;
          res_last = is_last;
          res_data = {5'd0, 3'(point_counter), s_axis_tdata, held_size_low,
                      clamped_y, clamped_x, held_track_id};
          if (is_last) begin
            expecting_points_next = 1'b0;
          end
        end
        default: ;
      endcase
      if (byte_in_record == POS_RESERVED) begin
        byte_in_record_next = POS_TRACK_ID;
        point_counter_next  = point_counter + 1'b1;
      end else begin
        byte_in_record_next = byte_in_record + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width     <= WIDTH_RESET;
      screen_height    <= HEIGHT_RESET;
      edge_margin      <= MARGIN_RESET;
      expecting_points <= 1'b0;
      points_expected  <= '0;
      point_counter    <= '0;
      byte_in_record   <= POS_TRACK_ID;
      held_track_id    <= '0;
      held_x           <= '0;
      held_y           <= '0;
      held_size_low    <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SCREEN_WIDTH:  screen_width  <= cfg_data;
          CFG_SCREEN_HEIGHT: screen_height <= cfg_data;
          CFG_EDGE_MARGIN:   edge_margin   <= cfg_data[6:0];
          default: ;
        endcase
      end
      if (accept) begin
        expecting_points <= expecting_points_next;
        points_expected  <= points_expected_next;
        point_counter    <= point_counter_next;
        byte_in_record   <= byte_in_record_next;
        held_track_id    <= held_track_id_next;
        held_x           <= held_x_next;
        held_y           <= held_y_next;
        held_size_low    <= held_size_low_next;
      end
      if (accept && produced) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept && produced) begin
      out_data <= res_data;
      out_kind <= res_kind;
      out_last <= res_last;
    end
  end

  `ASSERT_IMPL(a_status_word_last, clk, rst,
    m_axis_tvalid && (m_axis_tuser != KIND_POINT), m_axis_tlast,
    "status word without last")
  `ASSERT_IMPL(a_status_word_zero, clk, rst,
    m_axis_tvalid && (m_axis_tuser != KIND_POINT), m_axis_tdata == '0,
    "status word carries point data")
  `ASSERT_IMPL(a_counter_in_range, clk, rst,
    expecting_points, (point_counter < points_expected) && (points_expected != '0),
    "point counter beyond expected count")
  `ASSERT_ALWAYS(a_expected_bound, clk, rst,
    int'(points_expected) <= MAX_POINTS,
    "expected count above maximum")

endmodule
